/* rtl/rs3_pkg.sv */
// Shared types and constants for the raster_slope_3x3 block.
// Used by rs3_ctrl, rs3_dp and the top level; depends on nothing.
package rs3_pkg;

	localparam int MAX_W   = 4096;
	localparam int COL_W   = $clog2(MAX_W);
	localparam int PIX_W   = 24;
	localparam int ROOT_STEPS = 32;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_NODATA = 3'd2;
	localparam logic [2:0] REG_INV_X  = 3'd3;
	localparam logic [2:0] REG_INV_Y  = 3'd4;

	localparam logic [12:0] WIDTH_RST  = 13'd4096;
	localparam logic [15:0] HEIGHT_RST = 16'd4096;
	localparam logic [23:0] NODATA_RST = 24'hD8E100; // -10015 m in Q16.8
	localparam logic [31:0] INV_RST    = 32'd2796203;

	// controller -> datapath commands
	typedef struct packed {
		logic load_in;
		logic pos;
		logic rd;
		logic mulx;
		logic muly;
		logic sqx;
		logic sqy;
		logic sum;
		logic root;
		logic out_load;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic emit;
		logic nodata;
		logic root_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/rs3_ctrl.sv */
// Sequencer for raster_slope_3x3: walks one pixel through the datapath steps.
// Depends on rs3_pkg.
module rs3_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rs3_pkg::sts_t sts,
	output rs3_pkg::cmd_t cmd
);
	import rs3_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_POS, ST_RD, ST_MULX, ST_MULY, ST_SQX, ST_SQY, ST_SUM, ST_ROOT, ST_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd          = '0;
		in_ready     = (state_q == ST_IDLE);
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.pos      = (state_q == ST_POS);
		cmd.rd       = (state_q == ST_RD);
		cmd.mulx     = (state_q == ST_MULX);
		cmd.muly     = (state_q == ST_MULY);
		cmd.sqx      = (state_q == ST_SQX);
		cmd.sqy      = (state_q == ST_SQY);
		cmd.sum      = (state_q == ST_SUM);
		cmd.root     = (state_q == ST_ROOT);
		cmd.out_load = (state_q == ST_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_POS;
				ST_POS:  state_q <= ST_RD;
				ST_RD: begin
					if (!sts.emit)       state_q <= ST_IDLE;
					else if (sts.nodata) state_q <= ST_FIN;
					else                 state_q <= ST_MULX;
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: if (sts.root_done) state_q <= ST_FIN;
				ST_FIN:  if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/rs3_dp.sv */
// Datapath for raster_slope_3x3: registers, line stores, window, counters,
// gradient multipliers, squares, bit-serial root and output register. Needs rs3_pkg.
module rs3_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  rs3_pkg::cmd_t cmd,
	output rs3_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic [23:0]   in_pix,
	input  logic          in_fs,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_slope,
	output logic          out_nodata,
	output logic          out_last
);
	import rs3_pkg::*;

	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [23:0] nodata_q;
	logic [31:0] inv_x_q, inv_y_q;

	logic [23:0] line1 [MAX_W];
	logic [23:0] line2 [MAX_W];
	logic [23:0] top_q, mid_q;

	logic [23:0] pix_q;
	logic        fs_q;
	logic [23:0] win_q [6];
	logic [COL_W-1:0] col_q;
	logic [15:0] row_q;

	logic        nd_q, last_q, sat_q;
	logic [26:0] magx_q, magy_q;
	logic [58:0] prod_q;
	logic [42:0] dqx_q, dqy_q;
	logic [63:0] sqa_q, sqb_q;
	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  step_q;

	logic [12:0] w_eff;
	logic [15:0] h_eff;
	logic [12:0] pc;
	logic [16:0] pr;
	logic [12:0] nc;
	logic [16:0] nr;
	logic [25:0] left_s, right_s, top_s, bot_s;
	logic [26:0] dx, dy;
	logic [64:0] sum65;
	logic [33:0] rem_sh, trial;

	function automatic logic [25:0] pv(input logic [23:0] v, input logic [23:0] nd);
		pv = (v == nd) ? 26'd0 : {{2{v[23]}}, v};
	endfunction

	function automatic logic [26:0] mag27(input logic [26:0] d);
		mag27 = d[26] ? (~d + 27'd1) : d;
	endfunction

	assign w_eff = (width_q < 13'd3) ? 13'd3 :
		(width_q > 13'(MAX_W)) ? 13'(MAX_W) : width_q;
	assign h_eff = (height_q < 16'd3) ? 16'd3 : height_q;

	// position of the incoming pixel
	always_comb begin
		pc = fs_q ? 13'd0 : {1'b0, col_q};
		pr = fs_q ? 17'd0 : {1'b0, row_q};
		if (pc >= w_eff) begin
			pc = 13'd0;
			pr = pr + 17'd1;
		end
		if (pr >= {1'b0, h_eff}) pr = 17'd0;
	end

	// advance after the pixel
	always_comb begin
		nc = {1'b0, col_q} + 13'd1;
		nr = {1'b0, row_q};
		if (nc >= w_eff) begin
			nc = 13'd0;
			nr = nr + 17'd1;
			if (nr >= {1'b0, h_eff}) nr = 17'd0;
		end
	end

	// window sums: cols c-2 (win 0..2), c-1 (win 3..5), current (top, mid, pix)
	always_comb begin
		left_s  = pv(win_q[0], nodata_q) + pv(win_q[1], nodata_q) + pv(win_q[2], nodata_q);
		right_s = pv(top_q, nodata_q) + pv(mid_q, nodata_q) + pv(pix_q, nodata_q);
		top_s   = pv(win_q[0], nodata_q) + pv(win_q[3], nodata_q) + pv(top_q, nodata_q);
		bot_s   = pv(win_q[2], nodata_q) + pv(win_q[5], nodata_q) + pv(pix_q, nodata_q);
		dx = {right_s[25], right_s} - {left_s[25], left_s};
		dy = {top_s[25], top_s} - {bot_s[25], bot_s};
	end

	assign sum65  = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign rem_sh = {rem_q[31:0], val_q[63:62]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			nodata_q <= NODATA_RST;
			inv_x_q  <= INV_RST;
			inv_y_q  <= INV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[15:0];
				REG_NODATA: nodata_q <= cfg_data[23:0];
				REG_INV_X:  inv_x_q  <= cfg_data;
				REG_INV_Y:  inv_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// line stores
	always_ff @(posedge clk) begin
		if (cmd.pos) begin
			top_q <= line2[pc[COL_W-1:0]];
			mid_q <= line1[pc[COL_W-1:0]];
		end
		if (cmd.rd) begin
			line2[col_q] <= mid_q;
			line1[col_q] <= pix_q;
		end
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			fs_q      <= 1'b0;
			step_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			if (cmd.load_in) fs_q <= in_fs;
			if (cmd.pos) begin
				col_q <= pc[COL_W-1:0];
				row_q <= pr[15:0];
			end
			if (cmd.rd) begin
				col_q    <= nc[COL_W-1:0];
				row_q    <= nr[15:0];
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_q;
				win_q[4] <= mid_q;
				win_q[5] <= pix_q;
			end
			if (cmd.sum)  step_q <= '0;
			if (cmd.root) step_q <= step_q + 5'd1;
			if (cmd.out_load)             out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) pix_q <= in_pix;
		if (cmd.rd) begin
			nd_q   <= (win_q[4] == nodata_q);
			last_q <= (row_q == h_eff - 16'd1) && ({1'b0, col_q} == w_eff - 13'd1);
			magx_q <= mag27(dx);
			magy_q <= mag27(dy);
		end
		if (cmd.mulx) prod_q <= {32'd0, magx_q} * {27'd0, inv_x_q};
		if (cmd.muly) begin
			dqx_q  <= 43'((prod_q + 59'h8000) >> 16);
			prod_q <= {32'd0, magy_q} * {27'd0, inv_y_q};
		end
		if (cmd.sqx) begin
			dqy_q <= 43'((prod_q + 59'h8000) >> 16);
			sqa_q <= {32'd0, dqx_q[31:0]} * {32'd0, dqx_q[31:0]};
		end
		if (cmd.sqy) sqb_q <= {32'd0, dqy_q[31:0]} * {32'd0, dqy_q[31:0]};
		if (cmd.sum) begin
			sat_q  <= (dqx_q[42:32] != '0) || (dqy_q[42:32] != '0) || sum65[64];
			val_q  <= sum65[63:0];
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.root) begin
			val_q <= {val_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_slope  <= nd_q ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : root_q);
			out_nodata <= nd_q;
			out_last   <= last_q;
		end
	end

	assign sts.emit      = (row_q >= 16'd2) && (col_q >= COL_W'(2));
	assign sts.nodata    = (win_q[4] == nodata_q);
	assign sts.root_done = (step_q == 5'(ROOT_STEPS - 1));
	assign sts.out_free  = !out_valid || out_ready;

endmodule

/* rtl/raster_slope_3x3.sv */
// Top level of raster_slope_3x3: controller plus datapath.
// Depends on rs3_pkg, rs3_ctrl and rs3_dp.

// Terrain slope from a 3x3 Prewitt window over elevation pixels in raster
// order. Each pixel beat is taken one at a time. A border pixel passes the
// position and read steps only; an interior pixel with a nodata centre goes
// on to the output step; a valid centre first runs two gradient multipliers,
// two squarers and the 32-step bit-serial square root in turn. A finished
// result sits in the output register, so a stalled output holds the block only
// once the next result is ready. Border pixels produce no beat; nodata centres
// give slope 0 with the flag set in tuser; tlast marks the last interior pixel
// of the frame. Line stores need no clearing after reset.
module raster_slope_3x3 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [23:0] elevation
	input  logic        s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] slope
	output logic        m_tuser,  // [0] no_data
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rs3_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rs3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rs3_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_pix     (s_tdata),
		.in_fs      (s_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_slope  (m_tdata),
		.out_nodata (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

/* rtl/rs3_checker.sv */
// Port-level checks for raster_slope_3x3 and the bind that attaches them.
// Depends only on the top level's ports.
module rs3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// one pixel at a time: busy right after a beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// nodata result carries zero slope
	a_nd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("nodata beat with non-zero slope");

	// a new result rises only after the block has taken a pixel and is busy with it
	a_new_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind raster_slope_3x3 rs3_checker u_rs3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
